/* design/sha1_byte_stream_hasher_macros.svh */
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SHA1_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA1_BYTE_STREAM_HASHER_MACROS_SVH
`ifndef SYNTH
`define SHA1_BSH_ASSERT(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("sha1 hasher assertion failed");
`define SHA1_BSH_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("sha1 hasher assertion failed");
`else
`define SHA1_BSH_ASSERT(name, cond)
`define SHA1_BSH_ASSERT_NEXT(name, pre, post)
`endif
`endif

/* design/sha1_bsh_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-1 hasher package
// Shared types, constants and helper functions of the SHA-1 byte hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_bsh_pkg;

  typedef logic [31:0]      word_t;
  typedef logic [4:0][31:0] abcde_t;

  localparam int unsigned ROUNDS     = 80;
  localparam int unsigned ROUND_BITS = 7;

  localparam word_t ROUND_K0 = 32'h5a827999;
  localparam word_t ROUND_K1 = 32'h6ed9eba1;
  localparam word_t ROUND_K2 = 32'h8f1bbcdc;
  localparam word_t ROUND_K3 = 32'hca62c1d6;

  // Index 0 holds H0.
  localparam abcde_t INIT_VECTOR = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                    32'hefcdab89, 32'h67452301};

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LENGTH_POS = 6'd56;

  // Controls from the sequencer to the message schedule.
  typedef struct packed {
    logic       put;        // one message or pad byte enters
    logic [7:0] data;
    logic       word_done;  // the byte completes a 32-bit word
    logic       step;       // advance the schedule by one round
  } sched_ctl_t;

  function automatic word_t rotl1(word_t x);
    return {x[30:0], x[31]};
  endfunction

  function automatic word_t rotl5(word_t x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic word_t rotl30(word_t x);
    return {x[1:0], x[31:2]};
  endfunction

endpackage

`default_nettype wire

/* design/sha1_byte_stream_hasher.sv */
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher
// Absorbs message bytes, pads on finish and emits the five digest words.
// ----------------------------------------------------------------------------
// A data byte is taken whenever the input is not stalled. The byte ending a
// 64-byte block holds the input stalled for 80 rounds through the single
// shared round unit and a final step that folds the working words into the
// chain value. A finish transaction feeds the pad bytes, the 0x80 mark, zero
// fill and the eight length bytes, one per cycle through the same byte path
// outside compressions, runs one or two compressions, and then presents H0
// to H4 as five output transactions; the input stays stalled until the last
// word is taken. After that the hasher is back at the initial vector.
`default_nettype none

`include "sha1_byte_stream_hasher_macros.svh"

module sha1_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FINAL,
    ST_EMIT
  } state_e;

  state_e                                 state_q;
  sha1_bsh_pkg::abcde_t                   chain_q;
  sha1_bsh_pkg::abcde_t                   work_q;
  sha1_bsh_pkg::abcde_t                   work_next;
  logic [sha1_bsh_pkg::ROUND_BITS-1:0]    round_q;
  logic [5:0]                             fill_q;
  logic [31:0]                            msg_bytes_q;
  logic                                   first_q;
  logic                                   pad_q;
  logic                                   len_q;
  logic [2:0]                             widx_q;
  logic                                   in_acc;
  logic                                   out_acc;
  logic                                   put_c;
  logic [7:0]                             put_data_c;
  logic [7:0]                             pad_byte_c;
  sha1_bsh_pkg::sched_ctl_t               sched_ctl;
  sha1_bsh_pkg::word_t                    sched_w;

  function automatic logic [7:0] length_byte(logic [2:0] pos, logic [31:0] n);
    logic [7:0] r;
    unique case (pos)
      3'd3:    r = {5'd0, n[31:29]};
      3'd4:    r = n[28:21];
      3'd5:    r = n[20:13];
      3'd6:    r = n[12:5];
      3'd7:    r = {n[4:0], 3'd0};
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_acc        = in_valid_i && !in_stall_o;
  assign out_valid_o   = (state_q == ST_EMIT);
  assign out_acc       = out_valid_o && !out_stall_i;
  assign digest_word_o = chain_q[0];
  assign word_index_o  = widx_q;
  assign last_word_o   = (widx_q == 3'd4);

  // Length bytes start once the fill reaches the length position after the mark.
  always_comb begin
    priority if (first_q) begin
      pad_byte_c = sha1_bsh_pkg::PAD_MARK;
    end else if (len_q || (fill_q == sha1_bsh_pkg::LENGTH_POS)) begin
      pad_byte_c = length_byte(fill_q[2:0], msg_bytes_q);
    end else begin
      pad_byte_c = 8'd0;
    end
  end

  always_comb begin
    put_c      = 1'b0;
    put_data_c = pad_byte_c;
    if (state_q == ST_IDLE) begin
      put_c      = in_acc && !mode_i;
      put_data_c = data_byte_i;
    end else if (state_q == ST_PAD) begin
      put_c = 1'b1;
    end
  end

  assign sched_ctl.put       = put_c;
  assign sched_ctl.data      = put_data_c;
  assign sched_ctl.word_done = put_c && (fill_q[1:0] == 2'd3);
  assign sched_ctl.step      = (state_q == ST_COMP);

  sha1_bsh_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (sched_ctl),
    .w_o   (sched_w)
  );

  sha1_bsh_round u_round (
    .work_i  (work_q),
    .w_i     (sched_w),
    .round_i (round_q),
    .work_o  (work_next)
  );

  always_ff @(posedge clk_i) begin
    if ((put_c && (fill_q == 6'd63))) begin
      work_q <= chain_q;
    end else if (state_q == ST_COMP) begin
      work_q <= work_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chain_q     <= sha1_bsh_pkg::INIT_VECTOR;
      round_q     <= '0;
      fill_q      <= '0;
      msg_bytes_q <= '0;
      first_q     <= 1'b0;
      pad_q       <= 1'b0;
      len_q       <= 1'b0;
      widx_q      <= '0;
    end else begin
      if (put_c) begin
        fill_q <= fill_q + 6'd1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (mode_i) begin
              state_q <= ST_PAD;
              first_q <= 1'b1;
              pad_q   <= 1'b1;
              len_q   <= 1'b0;
            end else begin
              msg_bytes_q <= msg_bytes_q + 32'd1;
              if (fill_q == 6'd63) begin
                state_q <= ST_COMP;
                round_q <= '0;
              end
            end
          end
        end
        ST_PAD: begin
          first_q <= 1'b0;
          if (!first_q && (fill_q == sha1_bsh_pkg::LENGTH_POS)) begin
            len_q <= 1'b1;
          end
          if (fill_q == 6'd63) begin
            state_q <= ST_COMP;
            round_q <= '0;
          end
        end
        ST_COMP: begin
          round_q <= round_q + 7'd1;
          if (round_q == 7'(sha1_bsh_pkg::ROUNDS - 1)) begin
            state_q <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          for (int i = 0; i < 5; i++) begin
            chain_q[i] <= chain_q[i] + work_q[i];
          end
          if (!pad_q) begin
            state_q <= ST_IDLE;
          end else if (len_q) begin
            state_q <= ST_EMIT;
            widx_q  <= '0;
          end else begin
            state_q <= ST_PAD;
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            widx_q <= widx_q + 3'd1;
            if (widx_q == 3'd4) begin
              state_q     <= ST_IDLE;
              chain_q     <= sha1_bsh_pkg::INIT_VECTOR;
              fill_q      <= '0;
              msg_bytes_q <= '0;
              pad_q       <= 1'b0;
              len_q       <= 1'b0;
            end else begin
              chain_q <= {chain_q[0], chain_q[4:1]};
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `SHA1_BSH_ASSERT(a_round_range, (state_q != ST_COMP) || (round_q < 7'd80))
  `SHA1_BSH_ASSERT(a_emit_blocks_input, !out_valid_o || in_stall_o)
  `SHA1_BSH_ASSERT_NEXT(a_block_end_compress, in_acc && !mode_i && (fill_q == 6'd63), in_stall_o && (state_q == ST_COMP))
  `SHA1_BSH_ASSERT_NEXT(a_last_word_restart, out_acc && last_word_o, !in_stall_o && (fill_q == 6'd0))
  `SHA1_BSH_ASSERT(a_index_range, !out_valid_o || (widx_q <= 3'd4))

endmodule

`default_nettype wire

/* design/sha1_bsh_sched.sv */
// ----------------------------------------------------------------------------
// SHA-1 message schedule
// Packs bytes big-endian into words and holds the sixteen-word rolling
// schedule as a shift line with fixed taps.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_bsh_sched (
  input  logic                     clk_i,
  input  sha1_bsh_pkg::sched_ctl_t ctl_i,
  output sha1_bsh_pkg::word_t      w_o
);

  logic [23:0]               acc_q;
  sha1_bsh_pkg::word_t [15:0] sw_q;
  sha1_bsh_pkg::word_t       new_w;

  // Entry 0 is the word of the current round; the new word extends by 16.
  assign new_w = sha1_bsh_pkg::rotl1(sw_q[13] ^ sw_q[8] ^ sw_q[2] ^ sw_q[0]);
  assign w_o   = sw_q[0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.put) begin
      acc_q <= {acc_q[15:0], ctl_i.data};
      if (ctl_i.word_done) begin
        sw_q <= {{acc_q, ctl_i.data}, sw_q[15:1]};
      end
    end else if (ctl_i.step) begin
      sw_q <= {new_w, sw_q[15:1]};
    end
  end

endmodule

`default_nettype wire

/* design/sha1_bsh_round.sv */
// ----------------------------------------------------------------------------
// SHA-1 round unit
// One compression round: boolean function, constant and the five-way rotate.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_bsh_round (
  input  sha1_bsh_pkg::abcde_t                      work_i,
  input  sha1_bsh_pkg::word_t                       w_i,
  input  logic [sha1_bsh_pkg::ROUND_BITS-1:0]       round_i,
  output sha1_bsh_pkg::abcde_t                      work_o
);

  sha1_bsh_pkg::word_t a, b, c, d, e, f, k;

  assign a = work_i[0];
  assign b = work_i[1];
  assign c = work_i[2];
  assign d = work_i[3];
  assign e = work_i[4];

  always_comb begin
    priority if (round_i < 7'd20) begin
      f = d ^ (b & (c ^ d));
      k = sha1_bsh_pkg::ROUND_K0;
    end else if (round_i < 7'd40) begin
      f = b ^ c ^ d;
      k = sha1_bsh_pkg::ROUND_K1;
    end else if (round_i < 7'd60) begin
      f = (b & c) | (d & (b | c));
      k = sha1_bsh_pkg::ROUND_K2;
    end else begin
      f = b ^ c ^ d;
      k = sha1_bsh_pkg::ROUND_K3;
    end
  end

  assign work_o[0] = f + k + sha1_bsh_pkg::rotl5(a) + e + w_i;
  assign work_o[1] = a;
  assign work_o[2] = sha1_bsh_pkg::rotl30(b);
  assign work_o[3] = c;
  assign work_o[4] = d;

endmodule

`default_nettype wire

/* sim/sha1_tb_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-1 hasher testbench package
// Transaction codes shared by the stimulus and the digest checker.
// ----------------------------------------------------------------------------
package sha1_tb_pkg;

  typedef enum logic {
    MODE_ABSORB = 1'b0,
    MODE_FINISH = 1'b1
  } hash_mode_e;

endpackage

/* sim/sha1_digest_checker.sv */
// ----------------------------------------------------------------------------
// SHA-1 digest checker
// Follows every accepted input transaction with its own SHA-1 engine and
// compares each accepted digest word, field by field, in arrival order.
// ----------------------------------------------------------------------------
module sha1_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] digest_word_i,
  input  logic [2:0]  word_index_i,
  input  logic        last_word_i,
  output int unsigned fail_count_o,
  output int unsigned pending_words_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] K_ROUNDS_00 = 32'h5a827999;
  localparam logic [31:0] K_ROUNDS_20 = 32'h6ed9eba1;
  localparam logic [31:0] K_ROUNDS_40 = 32'h8f1bbcdc;
  localparam logic [31:0] K_ROUNDS_60 = 32'hca62c1d6;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam int unsigned LEN_OFFSET  = 56;
  localparam int unsigned DIGEST_LEN  = 5;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic [31:0]  hash_chain [5];
  logic [31:0]  msg_words  [16];
  int unsigned  fill_level;
  logic [31:0]  msg_length;
  digest_beat_t pending_digest [$];

  function automatic logic [31:0] rotate_left(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function void restart_hash();
    hash_chain[0] = 32'h67452301;
    hash_chain[1] = 32'hefcdab89;
    hash_chain[2] = 32'h98badcfe;
    hash_chain[3] = 32'h10325476;
    hash_chain[4] = 32'hc3d2e1f0;
    fill_level    = 0;
    msg_length    = '0;
  endfunction

  // The schedule is rolled over the sixteen block words in place.
  function void run_rounds();
    logic [31:0] a, b, c, d, e, f, w;
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    e = hash_chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        w = msg_words[(r + 13) & 15] ^ msg_words[(r + 8) & 15] ^
            msg_words[(r + 2) & 15] ^ msg_words[r & 15];
        msg_words[r & 15] = rotate_left(w, 1);
      end
      if (r < 20)      f = (d ^ (b & (c ^ d))) + K_ROUNDS_00;
      else if (r < 40) f = (b ^ c ^ d) + K_ROUNDS_20;
      else if (r < 60) f = ((b & c) | (d & (b | c))) + K_ROUNDS_40;
      else             f = (b ^ c ^ d) + K_ROUNDS_60;
      f = f + rotate_left(a, 5) + e + msg_words[r & 15];
      e = d;
      d = c;
      c = rotate_left(b, 30);
      b = a;
      a = f;
    end
    hash_chain[0] += a;
    hash_chain[1] += b;
    hash_chain[2] += c;
    hash_chain[3] += d;
    hash_chain[4] += e;
  endfunction

  function void load_byte(input logic [7:0] value);
    int unsigned idx, shift;
    idx   = fill_level >> 2;
    shift = (3 - (fill_level & 3)) * 8;
    msg_words[idx] = (msg_words[idx] & ~(32'hff << shift)) | ({24'b0, value} << shift);
    fill_level++;
    if (fill_level == 64) begin
      run_rounds();
      fill_level = 0;
    end
  endfunction

  // The length field carries the byte count times eight; its top bits stay zero.
  function void pad_and_emit();
    logic [31:0] n;
    n = msg_length;
    load_byte(PAD_BYTE);
    while (fill_level != LEN_OFFSET) load_byte(8'h00);
    repeat (3) load_byte(8'h00);
    load_byte({5'b0, n[31:29]});
    load_byte(n[28:21]);
    load_byte(n[20:13]);
    load_byte(n[12:5]);
    load_byte({n[4:0], 3'b000});
    for (int k = 0; k < DIGEST_LEN; k++)
      pending_digest.push_back('{hash_chain[k], 3'(k), k == DIGEST_LEN - 1});
    restart_hash();
  endfunction

  task flag_mismatch(input string what);
    $display("%0t ns: digest mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_beat_t got, want;
    if (!rst_ni) begin
      restart_hash();
      foreach (msg_words[i]) msg_words[i] = '0;
      pending_digest.delete();
      fail_count_o     = 0;
      pending_words_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{digest_word_i, word_index_i, last_word_i};
        if (pending_digest.size() == 0) begin
          flag_mismatch($sformatf("word %h index %0d arrived with nothing pending",
                                  got.word, got.index));
        end else begin
          want = pending_digest.pop_front();
          if (got.word !== want.word)
            flag_mismatch($sformatf("index %0d word %h, want %h", want.index, got.word,
                                    want.word));
          if (got.index !== want.index)
            flag_mismatch($sformatf("word_index %0d, want %0d", got.index, want.index));
          if (got.last !== want.last)
            flag_mismatch($sformatf("index %0d last_word %b, want %b", want.index,
                                    got.last, want.last));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (mode_i == sha1_tb_pkg::MODE_FINISH) begin
          pad_and_emit();
        end else begin
          msg_length = msg_length + 1;
          load_byte(data_byte_i);
        end
      end
      pending_words_o <= pending_digest.size();
    end
  end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher testbench
// Feeds directed and random messages with random idling on both channels,
// a long output hold-off and pauses for the digest, and gives the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET = 430;
  localparam int unsigned TAIL_ITEMS  = 60;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_WAIT  = 250;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid;
  logic                    in_stall_o;
  sha1_tb_pkg::hash_mode_e mode;
  logic [7:0]              data_byte;
  logic                    out_valid_o;
  logic                    out_stall;
  logic [31:0]             digest_word_o;
  logic [2:0]              word_index_o;
  logic                    last_word_o;
  int unsigned             fail_count;
  int unsigned             pending_words;

  int unsigned src_idle_level  = 0;
  int unsigned sink_idle_level = 0;
  bit          steady_tail     = 1'b0;
  bit          hold_request    = 1'b0;

  sha1_byte_stream_hasher dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode),
    .data_byte_i  (data_byte),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .digest_word_o(digest_word_o),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o)
  );

  sha1_digest_checker digest_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall_o),
    .mode_i         (mode),
    .data_byte_i    (data_byte),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall),
    .digest_word_i  (digest_word_o),
    .word_index_i   (word_index_o),
    .last_word_i    (last_word_o),
    .fail_count_o   (fail_count),
    .pending_words_o(pending_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Offers one transaction and holds it until taken, then maybe idles.
  task automatic offer(input sha1_tb_pkg::hash_mode_e m, input logic [7:0] value);
    in_valid  <= 1'b1;
    mode      <= m;
    data_byte <= value;
    do @(posedge clk_i); while (in_stall_o);
    if (!steady_tail && $urandom_range(0, 7) < src_idle_level) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_digest();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending_words == 0);
    @(posedge clk_i);
  endtask

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin : sink
    int unsigned stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left == 0) begin
        if (hold_request) begin
          hold_request = 1'b0;
          stall_left   = LONG_HOLD;
        end else if (!steady_tail && $urandom_range(0, 7) < sink_idle_level) begin
          stall_left = $urandom_range(1, 9);
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin : source
    int unsigned items_sent, len;
    items_sent = 0;
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    mode      <= sha1_tb_pkg::MODE_ABSORB;
    data_byte <= 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty messages back to back, then short ones, the data byte ignored on finish.
    offer(sha1_tb_pkg::MODE_FINISH, 8'hff);
    offer(sha1_tb_pkg::MODE_FINISH, 8'h00);
    offer(sha1_tb_pkg::MODE_ABSORB, "a");
    offer(sha1_tb_pkg::MODE_ABSORB, "b");
    offer(sha1_tb_pkg::MODE_ABSORB, "c");
    offer(sha1_tb_pkg::MODE_FINISH, 8'h5a);
    offer(sha1_tb_pkg::MODE_ABSORB, 8'h00);
    offer(sha1_tb_pkg::MODE_ABSORB, 8'hff);
    offer(sha1_tb_pkg::MODE_ABSORB, 8'h80);
    offer(sha1_tb_pkg::MODE_ABSORB, 8'h7f);
    offer(sha1_tb_pkg::MODE_ABSORB, 8'h01);
    offer(sha1_tb_pkg::MODE_FINISH, 8'h80);
    offer(sha1_tb_pkg::MODE_ABSORB, 8'h55);
    offer(sha1_tb_pkg::MODE_ABSORB, 8'haa);
    offer(sha1_tb_pkg::MODE_FINISH, 8'h01);
    wait_for_digest();

    // Output held off long enough that the input backs up behind a digest.
    hold_request = 1'b1;
    repeat (10) offer(sha1_tb_pkg::MODE_ABSORB, 8'($urandom_range(0, 255)));
    offer(sha1_tb_pkg::MODE_FINISH, 8'($urandom_range(0, 255)));
    repeat (3) offer(sha1_tb_pkg::MODE_ABSORB, 8'($urandom_range(0, 255)));
    offer(sha1_tb_pkg::MODE_FINISH, 8'($urandom_range(0, 255)));
    items_sent = 30;
    wait_for_digest();

    while (items_sent < ITEM_TARGET) begin
      src_idle_level  = $urandom_range(0, 3);
      sink_idle_level = $urandom_range(0, 3);
      steady_tail     = items_sent + TAIL_ITEMS >= ITEM_TARGET;
      // Mostly short messages, some on the padding boundaries, a few long.
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: len = $urandom_range(0, 12);
        6, 7: begin
          case ($urandom_range(0, 7))
            0: len = 55;
            1: len = 56;
            2: len = 57;
            3: len = 63;
            4: len = 64;
            5: len = 65;
            6: len = 119;
            default: len = 120;
          endcase
        end
        8: len = $urandom_range(13, 70);
        default: len = $urandom_range(100, 140);
      endcase
      repeat (len) offer(sha1_tb_pkg::MODE_ABSORB, 8'($urandom_range(0, 255)));
      offer(sha1_tb_pkg::MODE_FINISH, 8'($urandom_range(0, 255)));
      items_sent += len + 1;
      if (!steady_tail && $urandom_range(0, 9) == 0) wait_for_digest();
    end

    wait_for_digest();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
